// File: hdl/epoch_seconds_to_calendar_core_assert.svh
// Assertion helpers shared by the calendar converter.
`ifndef EPOCH_SECONDS_TO_CALENDAR_CORE_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define E2C_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define E2C_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/e2c_pkg.sv
package e2c_pkg;

  localparam int unsigned EpochW = 32;
  localparam int unsigned DaysW = 16;
  localparam int unsigned SecsW = 17;
  localparam int unsigned YearW = 12;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW = 5;
  localparam int unsigned HourW = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;

  localparam int unsigned SecsPerDay = 86400;
  localparam int unsigned SecsPerHour = 3600;
  localparam int unsigned SecsPerMin = 60;
  localparam int unsigned BaseYear = 1970;

  // 86400 is 675 * 2^7. The day count is ((t >> 7) * DayRecip) >> 35, which is
  // exact for every 25-bit shifted input since 25 bits times the rounding error
  // of the reciprocal stays below 2^35.
  localparam int unsigned DayShift = 7;
  localparam int unsigned DayOdd = 675;
  localparam int unsigned DayRecip = 50903317;
  localparam int unsigned DayRecipShift = 35;
  localparam int unsigned DayRecipW = 26;
  localparam int unsigned ScaledW = EpochW - DayShift;
  localparam int unsigned ProdW = ScaledW + DayRecipW;
  localparam int unsigned OddRemW = SecsW - DayShift;

  // Year residues are tracked by counters so the leap test needs no divider.
  localparam int unsigned BaseMod4 = BaseYear % 4;
  localparam int unsigned BaseMod100 = BaseYear % 100;
  localparam int unsigned BaseMod400 = BaseYear % 400;

  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [DaysW-1:0] days;
    logic [SecsW-1:0] secs;
  } day_split_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_SPLIT,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_YEAR,
    B_MONTH
  } back_state_t;

  typedef enum logic [1:0] {
    H_HOUR,
    H_MINUTE,
    H_DONE
  } hms_phase_t;

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] mon,
                                                input logic is_leap);
    logic [DayW-1:0] len;
    case (mon)
      4'd2:    len = is_leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// File: hdl/e2c_front.sv
module e2c_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [e2c_pkg::EpochW-1:0]       epoch_seconds,
  output logic                             busy,
  output logic                             push,
  output e2c_pkg::day_split_t              push_data,
  input  logic                             full
);

  e2c_pkg::front_state_t state, state_next;

  logic [e2c_pkg::EpochW-1:0]  dividend;
  logic [e2c_pkg::ScaledW-1:0] scaled;
  logic [e2c_pkg::ProdW-1:0]   prod;
  logic [e2c_pkg::DaysW-1:0]   quo_est;
  logic [e2c_pkg::ScaledW-1:0] back_mul;
  logic [e2c_pkg::ScaledW-1:0] odd_rem;
  logic [e2c_pkg::DaysW-1:0]   quo;
  logic [e2c_pkg::SecsW-1:0]   rem;
  logic                        accept;

  // Divide by 675 with a reciprocal multiply; the low seven bits pass through.
  assign scaled = dividend[e2c_pkg::EpochW-1:e2c_pkg::DayShift];
  assign quo_est = prod[e2c_pkg::DayRecipShift +: e2c_pkg::DaysW];
  assign back_mul = e2c_pkg::ScaledW'(quo_est) * e2c_pkg::ScaledW'(e2c_pkg::DayOdd);
  assign odd_rem = scaled - back_mul;

  always_comb begin
    state_next = state;
    case (state)
      e2c_pkg::F_IDLE:  if (start) state_next = e2c_pkg::F_MUL;
      e2c_pkg::F_MUL:   state_next = e2c_pkg::F_SPLIT;
      e2c_pkg::F_SPLIT: state_next = e2c_pkg::F_PUSH;
      e2c_pkg::F_PUSH:  if (!full) state_next = e2c_pkg::F_IDLE;
      default:          state_next = e2c_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    busy = state != e2c_pkg::F_IDLE;
    accept = (state == e2c_pkg::F_IDLE) && start;
    push = (state == e2c_pkg::F_PUSH) && !full;
    push_data.days = quo;
    push_data.secs = rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= e2c_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dividend <= epoch_seconds;
    end
    if (state == e2c_pkg::F_MUL) begin
      prod <= e2c_pkg::ProdW'(scaled) * e2c_pkg::ProdW'(e2c_pkg::DayRecip);
    end
    if (state == e2c_pkg::F_SPLIT) begin
      quo <= quo_est;
      rem <= {odd_rem[e2c_pkg::OddRemW-1:0], dividend[e2c_pkg::DayShift-1:0]};
    end
  end

endmodule

// File: hdl/e2c_queue.sv
module e2c_queue #(
  parameter int unsigned DEPTH = e2c_pkg::QueueDepth
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  e2c_pkg::day_split_t push_data,
  output logic                full,
  input  logic                pop,
  output e2c_pkg::day_split_t pop_data,
  output logic                empty
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  e2c_pkg::day_split_t entries [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full = count == CntW'(DEPTH);
  assign empty = count == '0;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hdl/e2c_back.sv
module e2c_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              empty,
  input  e2c_pkg::day_split_t               pop_data,
  output logic                              pop,
  output logic                              done,
  output logic [e2c_pkg::YearW-1:0]         year,
  output logic [e2c_pkg::MonthW-1:0]        month,
  output logic [e2c_pkg::DayW-1:0]          day_of_month,
  output logic [e2c_pkg::HourW-1:0]         hour,
  output logic [e2c_pkg::MinuteW-1:0]       minute,
  output logic [e2c_pkg::SecondW-1:0]       second
);

  e2c_pkg::back_state_t state, state_next;
  e2c_pkg::hms_phase_t  phase;

  logic [e2c_pkg::DaysW-1:0]   days;
  logic [e2c_pkg::SecsW-1:0]   rem;
  logic [e2c_pkg::YearW-1:0]   cur_year;
  logic [e2c_pkg::MonthW-1:0]  cur_month;
  logic [e2c_pkg::HourW-1:0]   hr;
  logic [e2c_pkg::MinuteW-1:0] mn;
  logic [1:0]                  mod4;
  logic [6:0]                  mod100;
  logic [8:0]                  mod400;

  logic                        leap;
  logic [8:0]                  ylen;
  logic [e2c_pkg::DayW-1:0]    mlen;
  logic                        year_fin;
  logic                        hms_fin;
  logic                        month_fin;
  logic                        year_step;
  logic                        year_phase;
  logic                        month_step;
  logic                        finish;

  assign leap = ((mod4 == 2'd0) && (mod100 != 7'd0)) || (mod400 == 9'd0);
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = e2c_pkg::month_len(cur_month, leap);
  assign year_fin = days < e2c_pkg::DaysW'(ylen);
  assign hms_fin = phase == e2c_pkg::H_DONE;
  assign month_fin = (cur_month == 4'd12) || (days < e2c_pkg::DaysW'(mlen));

  always_comb begin
    state_next = state;
    case (state)
      e2c_pkg::B_IDLE:  if (!empty) state_next = e2c_pkg::B_YEAR;
      e2c_pkg::B_YEAR:  if (year_fin && hms_fin) state_next = e2c_pkg::B_MONTH;
      e2c_pkg::B_MONTH: if (month_fin) state_next = e2c_pkg::B_IDLE;
      default:          state_next = e2c_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop = (state == e2c_pkg::B_IDLE) && !empty;
    year_phase = state == e2c_pkg::B_YEAR;
    year_step = year_phase && !year_fin;
    month_step = (state == e2c_pkg::B_MONTH) && !month_fin;
    finish = (state == e2c_pkg::B_MONTH) && month_fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= e2c_pkg::B_IDLE;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      days <= pop_data.days;
      rem <= pop_data.secs;
      cur_year <= e2c_pkg::YearW'(e2c_pkg::BaseYear);
      cur_month <= 4'd1;
      mod4 <= 2'(e2c_pkg::BaseMod4);
      mod100 <= 7'(e2c_pkg::BaseMod100);
      mod400 <= 9'(e2c_pkg::BaseMod400);
      hr <= '0;
      mn <= '0;
      phase <= e2c_pkg::H_HOUR;
    end else begin
      if (year_step) begin
        days <= days - e2c_pkg::DaysW'(ylen);
        cur_year <= cur_year + 1'b1;
        mod4 <= mod4 + 2'd1;
        mod100 <= (mod100 == 7'd99) ? 7'd0 : mod100 + 7'd1;
        mod400 <= (mod400 == 9'd399) ? 9'd0 : mod400 + 9'd1;
      end else if (month_step) begin
        days <= days - e2c_pkg::DaysW'(mlen);
        cur_month <= cur_month + 4'd1;
      end
      // The time of day splits while the year loop runs.
      if (year_phase) begin
        case (phase)
          e2c_pkg::H_HOUR: begin
            if (rem >= e2c_pkg::SecsW'(e2c_pkg::SecsPerHour)) begin
              rem <= rem - e2c_pkg::SecsW'(e2c_pkg::SecsPerHour);
              hr <= hr + 1'b1;
            end else begin
              phase <= e2c_pkg::H_MINUTE;
            end
          end
          e2c_pkg::H_MINUTE: begin
            if (rem >= e2c_pkg::SecsW'(e2c_pkg::SecsPerMin)) begin
              rem <= rem - e2c_pkg::SecsW'(e2c_pkg::SecsPerMin);
              mn <= mn + 1'b1;
            end else begin
              phase <= e2c_pkg::H_DONE;
            end
          end
          default: phase <= e2c_pkg::H_DONE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      year <= cur_year;
      month <= cur_month;
      day_of_month <= days[e2c_pkg::DayW-1:0] + 5'd1;
      hour <= hr;
      minute <= mn;
      second <= rem[e2c_pkg::SecondW-1:0];
    end
  end

endmodule

// File: hdl/epoch_seconds_to_calendar_core.sv
// Channel   Handshake                 Payload
// input     start, busy               epoch_seconds
// result    done (one-cycle strobe)   year, month, day_of_month, hour, minute, second
//
// A transaction is accepted at a rising edge with start high and busy low; busy then
// stays high through the multiply, split and hand-off states, longer while the queue is full.
// The back unit sets the rate: a pop, then year steps that overlap the time split,
// then month steps up to December. done is registered from the final month state and
// rises in the cycle after the walk ends. Reset (rst, synchronous) empties the queue
// and idles both units; no receiver stall.

`include "epoch_seconds_to_calendar_core_assert.svh"

module epoch_seconds_to_calendar_core #(
  parameter int unsigned QUEUE_DEPTH = e2c_pkg::QueueDepth
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [e2c_pkg::EpochW-1:0]        epoch_seconds,
  output logic                              busy,
  output logic                              done,
  output logic [e2c_pkg::YearW-1:0]         year,
  output logic [e2c_pkg::MonthW-1:0]        month,
  output logic [e2c_pkg::DayW-1:0]          day_of_month,
  output logic [e2c_pkg::HourW-1:0]         hour,
  output logic [e2c_pkg::MinuteW-1:0]       minute,
  output logic [e2c_pkg::SecondW-1:0]       second
);

  // Handoff between the divider and the calendar walker.
  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_empty;
  e2c_pkg::day_split_t q_in;
  e2c_pkg::day_split_t q_out;
  logic                result_ok;

  // The front splits the timestamp into whole days and seconds of day
  // with a reciprocal multiplication by 1/86400 over its multiply and split states.
  e2c_front u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .epoch_seconds (epoch_seconds),
    .busy          (busy),
    .push          (q_push),
    .push_data     (q_in),
    .full          (q_full)
  );

  // The queue lets the front take a new transaction while the back is walking.
  e2c_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  // The back walks years while splitting the time of day, then months,
  // and registers the result for a single done strobe.
  e2c_back u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (q_empty),
    .pop_data     (q_out),
    .pop          (q_pop),
    .done         (done),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .hour         (hour),
    .minute       (minute),
    .second       (second)
  );

  // Every result must be a valid calendar time.
  assign result_ok = (month >= 4'd1) && (month <= 4'd12) && (day_of_month != 5'd0) &&
                     (hour < 5'd24) && (minute < 6'd60) && (second < 6'd60);

  // An accepted transaction must occupy the front on the next cycle.
  `E2C_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "front did not go busy after accept")
  // The front must never hand off into a full queue.
  `E2C_ASSERT_IMPL(a_no_push_full, q_push, !q_full, "push into full queue")
  // Each walk passes through the pop, year and month states, so results never come back to back.
  `E2C_ASSERT_NEXT(a_done_single, done, !done, "done strobe held for two cycles")
  `E2C_ASSERT_IMPL(a_done_range, done, result_ok, "result field out of range")

endmodule

// File: sim/epoch_to_calendar_checker.sv
`timescale 1ns / 1ps

module epoch_to_calendar_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               busy,
  input  logic [e2c_pkg::EpochW-1:0]         epoch_seconds,
  input  logic                               done,
  input  logic [e2c_pkg::YearW-1:0]          year,
  input  logic [e2c_pkg::MonthW-1:0]         month,
  input  logic [e2c_pkg::DayW-1:0]           day_of_month,
  input  logic [e2c_pkg::HourW-1:0]          hour,
  input  logic [e2c_pkg::MinuteW-1:0]        minute,
  input  logic [e2c_pkg::SecondW-1:0]        second,
  output int unsigned                        fail_count,
  output int unsigned                        pending,
  output int unsigned                        accepted_count,
  output int unsigned                        checked_count,
  output int unsigned                        leap_day_count
);
  import e2c_pkg::*;

  typedef struct packed {
    logic [YearW-1:0]   year;
    logic [MonthW-1:0]  month;
    logic [DayW-1:0]    day;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
  } calendar_t;

  typedef struct packed {
    logic [EpochW-1:0] stamp;
    calendar_t         date;
  } pending_date_t;

  pending_date_t expected_dates[$];

  function automatic bit has_leap_day(input int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  // Odd months up to July and even months from August on have 31 days.
  function automatic int unsigned days_in_month(input int unsigned mon, input bit leap);
    logic [3:0] m;
    m = mon[3:0];
    if (m == 4'd2) return leap ? 29 : 28;
    return 30 + (m[0] ^ m[3]);
  endfunction

  function automatic calendar_t to_calendar(input logic [EpochW-1:0] stamp);
    int unsigned days, secs, yr, mon;
    calendar_t c;
    days = stamp / SecsPerDay;
    secs = stamp % SecsPerDay;
    yr = BaseYear;
    while (days >= (has_leap_day(yr) ? 366 : 365)) begin
      days -= has_leap_day(yr) ? 366 : 365;
      yr++;
    end
    mon = 1;
    while (mon < 12 && days >= days_in_month(mon, has_leap_day(yr))) begin
      days -= days_in_month(mon, has_leap_day(yr));
      mon++;
    end
    c.year   = yr[YearW-1:0];
    c.month  = mon[MonthW-1:0];
    c.day    = days[DayW-1:0] + 1'b1;
    c.hour   = HourW'(secs / SecsPerHour);
    c.minute = MinuteW'((secs % SecsPerHour) / SecsPerMin);
    c.second = SecondW'(secs % SecsPerMin);
    return c;
  endfunction

  function automatic string fmt_date(input calendar_t c);
    return $sformatf("%0d-%0d-%0d %0d:%0d:%0d",
                     c.year, c.month, c.day, c.hour, c.minute, c.second);
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
    accepted_count = 0;
    checked_count = 0;
    leap_day_count = 0;
  end

  always @(posedge clk) begin
    pending_date_t head;
    calendar_t got;
    if (!rst) begin
      if (start && !busy) begin
        expected_dates.push_back('{stamp: epoch_seconds, date: to_calendar(epoch_seconds)});
        accepted_count <= accepted_count + 1;
      end
      if (done) begin
        got = '{year: year, month: month, day: day_of_month, hour: hour,
                minute: minute, second: second};
        if (expected_dates.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("[%0t] ERROR: result %s with no transaction pending",
                     $realtime, fmt_date(got));
        end else begin
          head = expected_dates.pop_front();
          checked_count <= checked_count + 1;
          if (head.date.month == 4'd2 && head.date.day == 5'd29)
            leap_day_count <= leap_day_count + 1;
          if (got.year != head.date.year || got.month != head.date.month ||
              got.day != head.date.day || got.hour != head.date.hour ||
              got.minute != head.date.minute || got.second != head.date.second) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("[%0t] ERROR: epoch %0d expected %s got %s",
                       $realtime, head.stamp, fmt_date(head.date), fmt_date(got));
          end
        end
      end
      pending <= expected_dates.size();
    end
  end

endmodule

// File: sim/epoch_seconds_to_calendar_core_tb.sv
`timescale 1ns / 1ps

// Top of the calendar converter testbench. This module only makes stimulus and
// gives the verdict; the checker beside the block predicts every result and
// compares it field by field.
module epoch_seconds_to_calendar_core_tb;
  import e2c_pkg::*;

  // The 1624 transactions of the run, idle gaps included, stay far below
  // this limit even several times over.
  localparam int unsigned CycleLimit = 2_000_000;
  // Enough cycles after the last result for anything still in flight to show.
  localparam int unsigned DrainCycles = 400;
  localparam int unsigned PhaseItems = 400;
  // Last day number that a 32-bit count of seconds reaches; it fits only in part.
  localparam int unsigned LastDay = 49710;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic [EpochW-1:0]    epoch_seconds;
  logic                 busy;
  logic                 done;
  logic [YearW-1:0]     year;
  logic [MonthW-1:0]    month;
  logic [DayW-1:0]      day_of_month;
  logic [HourW-1:0]     hour;
  logic [MinuteW-1:0]   minute;
  logic [SecondW-1:0]   second;

  int unsigned fail_count, pending, accepted_count, checked_count, leap_day_count;
  int unsigned cycle_count;

  epoch_seconds_to_calendar_core uut (
    .clk(clk), .rst(rst), .start(start), .epoch_seconds(epoch_seconds),
    .busy(busy), .done(done), .year(year), .month(month),
    .day_of_month(day_of_month), .hour(hour), .minute(minute), .second(second)
  );

  epoch_to_calendar_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .epoch_seconds(epoch_seconds),
    .done(done), .year(year), .month(month), .day_of_month(day_of_month),
    .hour(hour), .minute(minute), .second(second),
    .fail_count(fail_count), .pending(pending), .accepted_count(accepted_count),
    .checked_count(checked_count), .leap_day_count(leap_day_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Presents one timestamp and returns at the edge that accepts it. Start is
  // left high afterwards, so back-to-back transactions keep it asserted without
  // a drop; it is lowered only when the sender decides to idle.
  task automatic send_epoch(input logic [EpochW-1:0] stamp, input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    epoch_seconds <= stamp;
    do @(posedge clk); while (busy);
  endtask

  // Random timestamps. Roughly a third are raw 32-bit values, which toggle every
  // input bit; the rest are built from a day number and a time of day that is
  // often the first or last second, and over half of those days are picked by
  // year: the start of a year, the end of February, the end of a year or any day
  // within it, where the leap-year rules decide the answer.
  task automatic run_phase(input int unsigned count, input int unsigned idle_pct);
    int unsigned mode, day_no, sod, yr;
    longint unsigned wide;
    for (int unsigned n = 0; n < count; n++) begin
      mode = $urandom_range(9);
      if (mode < 3) begin
        wide = $urandom();
      end else begin
        if (mode < 6) begin
          day_no = $urandom_range(LastDay);
        end else begin
          yr = $urandom_range(2106, BaseYear + 1);
          day_no = 0;
          for (int unsigned y = BaseYear; y < yr; y++)
            day_no += (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0)) ? 366 : 365;
          case ($urandom_range(3))
            0: day_no -= 1;
            1: day_no += 0;
            2: day_no += 58 + $urandom_range(2);
            default: day_no += $urandom_range(364);
          endcase
        end
        case ($urandom_range(3))
          0: sod = 0;
          1: sod = SecsPerDay - 1;
          default: sod = $urandom_range(SecsPerDay - 1);
        endcase
        wide = longint'(day_no) * SecsPerDay + sod;
        if (wide > 64'hFFFF_FFFF) wide = 64'hFFFF_FFFF;
      end
      send_epoch(wide[EpochW-1:0], idle_pct);
    end
  endtask

  task automatic wait_for_results;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    epoch_seconds = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners: first and last second of minutes, hours and days, the
    // first year boundary, a leap day in an ordinary leap year, the century
    // years 2000 (leap) and 2100 (not leap), the 2038 sign boundary, the last
    // year boundary and the largest count, plus alternating bit patterns.
    send_epoch(32'd0, 0);
    send_epoch(32'd59, 0);
    send_epoch(32'd60, 0);
    send_epoch(32'd3599, 0);
    send_epoch(32'd3600, 0);
    send_epoch(32'd86399, 0);
    send_epoch(32'd86400, 0);
    send_epoch(32'd31535999, 0);
    send_epoch(32'd31536000, 0);
    send_epoch(32'd68169600, 0);
    send_epoch(32'd68255999, 0);
    send_epoch(32'd68256000, 0);
    send_epoch(32'd94694399, 0);
    send_epoch(32'd946684799, 0);
    send_epoch(32'd951782400, 0);
    send_epoch(32'd4107456000, 0);
    send_epoch(32'd4107542400, 0);
    send_epoch(32'h7FFF_FFFF, 0);
    send_epoch(32'h8000_0000, 0);
    send_epoch(32'd4291747199, 0);
    send_epoch(32'd4291747200, 0);
    send_epoch(32'hFFFF_FFFF, 0);
    send_epoch(32'hAAAA_AAAA, 0);
    send_epoch(32'h5555_5555, 0);

    // The sender holds off here until the block has drained completely, so the
    // next transaction starts from a fully idle block.
    wait_for_results();

    // Pacing phases: back to back, sender idle most of the time, sender idle
    // about a quarter of the time, and back to back again.
    run_phase(PhaseItems, 0);
    run_phase(PhaseItems, 60);
    run_phase(PhaseItems, 27);
    run_phase(PhaseItems, 0);

    wait_for_results();
    repeat (DrainCycles) @(posedge clk);

    $display("Converted %0d timestamps in %0d cycles; %0d results checked, %0d on Feb 29.",
             accepted_count, cycle_count, checked_count, leap_day_count);
    $display("Stimulus covered year, month and day boundaries from 1970 through 2106.");
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, pending);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
